FILE: hdl/dtq_pkg.sv
// Package for the deadline timer queue.
// Holds the operation codes, the controller state type and the fixed field widths.
// Has no dependencies.
package dtq_pkg;

   localparam int SLOT_W     = 4;
   localparam int DELAY_W    = 32;
   localparam int NOW_W      = 48;
   localparam int FIRE_LIMIT = 16;
   localparam int FCNT_W     = 5;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_START  = 2'd1,
      OP_CANCEL = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage

FILE: hdl/deadline_timer_queue_core.sv
// Deadline timer queue: NUM_SLOTS timer slots sharing one millisecond clock.
// Each scan reads every slot from the slot RAM once.
// Start, cancel, no-op and ticks without firing: one scan per item.
// A tick that fires k slots runs k + 1 scans, one result per scan after the first.
// One item at a time; the next item is taken while the last result still waits.
// Synchronous active-high reset clears time and all armed flags; slot RAM is not cleared.
module deadline_timer_queue_core
   import dtq_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0], slot[5:2], delay_ms[37:6], repeating[38], zero[39]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fired_slot[3:0], queue_empty[4], next_wait_ms[36:5], zero[39:37]
   output logic [39:0] rsp_tdata,
   // fired[0]
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int IW    = $clog2(NUM_SLOTS);
   localparam int RAM_W = DELAY_W + NOW_W;

   // Input fields.
   op_type              req_op;
   logic [SLOT_W-1:0]   req_slot;
   logic [DELAY_W-1:0]  req_delay;
   logic                req_rep;
   logic [SLOT_W+IW-1:0] slot_wide;
   logic [IW-1:0]       slot_idx;
   logic                slot_ok;
   logic                req_acc;

   assign req_op    = op_type'(req_tdata[1:0]);
   assign req_slot  = req_tdata[5:2];
   assign req_delay = req_tdata[37:6];
   assign req_rep   = req_tdata[38];
   assign slot_wide = {{IW{1'b0}}, req_slot};
   assign slot_idx  = slot_wide[IW-1:0];
   assign slot_ok   = slot_wide < (SLOT_W+IW)'(NUM_SLOTS);

   // Control state.
   state_type            state_ff, state_in;
   logic [NOW_W-1:0]     now_ff;
   logic [NUM_SLOTS-1:0] armed_ff;
   logic [NUM_SLOTS-1:0] rep_ff;
   logic [NUM_SLOTS-1:0] fmask_ff;
   logic                 tick_ff;
   logic [FCNT_W-1:0]    fcnt_ff;
   logic [IW-1:0]        issue_idx_ff;
   logic                 issue_done_ff;
   logic                 rdv_ff;
   logic [IW-1:0]        ridx_ff;

   // Scan accumulators.
   logic                 st_found_ff;
   logic [NOW_W-1:0]     st_d_ff;
   logic                 c_found_ff;
   logic [NOW_W-1:0]     c_d_ff;
   logic [IW-1:0]        c_idx_ff;
   logic [DELAY_W-1:0]   c_per_ff;
   logic                 prev_ff;
   logic [IW-1:0]        prev_idx_ff;

   // Result register.
   logic                 rsp_valid_ff;
   logic                 rsp_fired_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_empty_ff;
   logic [DELAY_W-1:0]   rsp_wait_ff;
   logic                 rsp_last_ff;

   // RAM port signals.
   logic                 ram_we;
   logic [IW-1:0]        ram_waddr;
   logic [RAM_W-1:0]     ram_wdata;
   logic                 ram_re;
   logic [RAM_W-1:0]     ram_rdata;
   logic [DELAY_W-1:0]   rd_per;
   logic [NOW_W-1:0]     rd_dl;

   // Decision signals.
   logic                 out_free;
   logic                 emit;
   logic                 proceed;
   logic                 scan_last;
   logic [NOW_W-1:0]     diff;
   logic [DELAY_W-1:0]   wait_val;
   logic [SLOT_W+IW-1:0] prev_wide;

   assign rd_per = ram_rdata[RAM_W-1:NOW_W];
   assign rd_dl  = ram_rdata[NOW_W-1:0];

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = prev_ff || !c_found_ff;
   assign proceed   = !emit || out_free;
   assign scan_last = rdv_ff && (ridx_ff == IW'(NUM_SLOTS - 1));
   assign prev_wide = {{SLOT_W{1'b0}}, prev_idx_ff};

   dtq_ram #(
      .WIDTH(RAM_W),
      .DEPTH(NUM_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(issue_idx_ff),
      .rd_data(ram_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (proceed) state_in = c_found_ff ? ST_SCAN : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the controller.
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = c_idx_ff;
      ram_wdata  = {c_per_ff, now_ff + {{(NOW_W-DELAY_W){1'b0}}, c_per_ff}};
      ram_re     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ram_waddr  = slot_idx;
            ram_wdata  = {req_delay, now_ff + {{(NOW_W-DELAY_W){1'b0}}, req_delay}};
            ram_we     = req_acc && (req_op == OP_START) && slot_ok;
         end
         ST_SCAN: begin
            ram_re = !issue_done_ff;
         end
         ST_DECIDE: begin
            ram_we = proceed && c_found_ff && rep_ff[c_idx_ff];
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign req_acc = req_tvalid && req_tready;

   // Wait time to the earliest armed deadline.
   assign diff = st_d_ff - now_ff;
   always_comb begin
      if (st_d_ff <= now_ff) begin
         wait_val = '0;
      end else if (diff[NOW_W-1:DELAY_W] != '0) begin
         wait_val = '1;
      end else begin
         wait_val = diff[DELAY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         armed_ff      <= '0;
         rep_ff        <= '0;
         fmask_ff      <= '0;
         tick_ff       <= 1'b0;
         fcnt_ff       <= '0;
         issue_idx_ff  <= '0;
         issue_done_ff <= 1'b0;
         rdv_ff        <= 1'b0;
         st_found_ff   <= 1'b0;
         c_found_ff    <= 1'b0;
         prev_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= ram_re;
         ridx_ff  <= issue_idx_ff;
         if ((state_ff == ST_DECIDE) && proceed && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  tick_ff       <= (req_op == OP_TICK);
                  fcnt_ff       <= '0;
                  fmask_ff      <= '0;
                  prev_ff       <= 1'b0;
                  issue_idx_ff  <= '0;
                  issue_done_ff <= 1'b0;
                  st_found_ff   <= 1'b0;
                  c_found_ff    <= 1'b0;
                  if (req_op == OP_TICK) now_ff <= now_ff + NOW_W'(1);
                  if (req_op == OP_START && slot_ok) begin
                     armed_ff[slot_idx] <= 1'b1;
                     rep_ff[slot_idx]   <= req_rep;
                  end
                  if (req_op == OP_CANCEL && slot_ok) armed_ff[slot_idx] <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (!issue_done_ff) begin
                  if (issue_idx_ff == IW'(NUM_SLOTS - 1)) begin
                     issue_done_ff <= 1'b1;
                  end else begin
                     issue_idx_ff <= issue_idx_ff + IW'(1);
                  end
               end
               if (rdv_ff && armed_ff[ridx_ff]) begin
                  // Strict compares keep the lowest index on equal deadlines.
                  if (!st_found_ff || rd_dl < st_d_ff) begin
                     st_found_ff <= 1'b1;
                     st_d_ff     <= rd_dl;
                  end
                  if (tick_ff && !fmask_ff[ridx_ff] && rd_dl <= now_ff
                      && fcnt_ff < FCNT_W'(FIRE_LIMIT)
                      && (!c_found_ff || rd_dl < c_d_ff)) begin
                     c_found_ff <= 1'b1;
                     c_d_ff     <= rd_dl;
                     c_idx_ff   <= ridx_ff;
                     c_per_ff   <= rd_per;
                  end
               end
            end
            ST_DECIDE: begin
               if (proceed) begin
                  if (emit) begin
                     rsp_fired_ff <= prev_ff;
                     rsp_slot_ff  <= prev_ff ? prev_wide[SLOT_W-1:0] : '0;
                     rsp_empty_ff <= !st_found_ff;
                     rsp_wait_ff  <= st_found_ff ? wait_val : '0;
                     rsp_last_ff  <= !c_found_ff;
                  end
                  if (c_found_ff) begin
                     fmask_ff[c_idx_ff] <= 1'b1;
                     fcnt_ff            <= fcnt_ff + FCNT_W'(1);
                     prev_ff            <= 1'b1;
                     prev_idx_ff        <= c_idx_ff;
                     if (!rep_ff[c_idx_ff]) armed_ff[c_idx_ff] <= 1'b0;
                  end else begin
                     prev_ff <= 1'b0;
                  end
                  issue_idx_ff  <= '0;
                  issue_done_ff <= 1'b0;
                  st_found_ff   <= 1'b0;
                  c_found_ff    <= 1'b0;
               end
            end
            default: begin
               prev_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {3'b000, rsp_wait_ff, rsp_empty_ff, rsp_slot_ff};
   assign rsp_tuser[0] = rsp_fired_ff;
   assign rsp_tlast    = rsp_last_ff;

`ifndef ASSERT_OFF
   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= FCNT_W'(FIRE_LIMIT))
      else $error("more firings in one tick than the limit");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_we)
      else $error("slot RAM written during a scan");

   a_status_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tlast)
      else $error("status transaction not marked final");

   a_empty_wait_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[4]) |-> (rsp_tdata[36:5] == '0))
      else $error("empty queue reports a nonzero wait");
`endif

endmodule

FILE: hdl/dtq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the per-slot period and deadline storage.
// No dependencies.
module dtq_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: verif/deadline_timer_queue_core_tb.sv
// Self-checking testbench for deadline_timer_queue_core.
// Drives tick, start, cancel and no-op transactions and checks every firing and status result.
// Depends on dtq_pkg and the deadline_timer_queue_core RTL.
module deadline_timer_queue_core_tb
   import dtq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT     = 16;
   localparam int STALL_MAX = 20000;

   typedef struct packed {
      logic        fired;
      logic [3:0]  fired_slot;
      logic        queue_empty;
      logic [31:0] next_wait_ms;
      logic        last;
   } timer_result_type;

   class timer_scoreboard;
      logic [47:0] clock_ms;
      bit          is_armed [NSLOT];
      bit          is_repeat [NSLOT];
      logic [31:0] period [NSLOT];
      logic [47:0] deadline [NSLOT];
      timer_result_type expected_q [$];
      int          errors;

      function void clear();
         clock_ms = '0;
         errors = 0;
         expected_q.delete();
         for (int s = 0; s < NSLOT; s++) begin
            is_armed[s] = 0;
            is_repeat[s] = 0;
            period[s] = '0;
            deadline[s] = '0;
         end
      endfunction

      function timer_result_type status(bit fired, int which);
         timer_result_type r;
         int best;
         logic [47:0] diff;
         best = -1;
         for (int s = 0; s < NSLOT; s++)
            if (is_armed[s] && (best < 0 || deadline[s] < deadline[best])) best = s;
         r.fired = fired;
         r.fired_slot = fired ? which[3:0] : 4'd0;
         r.last = 0;
         r.queue_empty = (best < 0);
         r.next_wait_ms = '0;
         if (best >= 0 && deadline[best] > clock_ms) begin
            diff = deadline[best] - clock_ms;
            r.next_wait_ms = (diff > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
         end
         return r;
      endfunction

      // Works out every result of one accepted transaction and queues it.
      function void note_request(op_type op, logic [3:0] slot, logic [31:0] delay, bit rep);
         bit pending [NSLOT];
         int count, best;
         timer_result_type batch [$];
         count = 0;
         if (op == OP_TICK) begin
            clock_ms = clock_ms + 48'd1;
            for (int s = 0; s < NSLOT; s++)
               pending[s] = is_armed[s] && deadline[s] <= clock_ms;
            while (count < FIRE_LIMIT) begin
               best = -1;
               for (int s = 0; s < NSLOT; s++)
                  if (pending[s] && (best < 0 || deadline[s] < deadline[best])) best = s;
               if (best < 0) break;
               pending[best] = 0;
               if (is_repeat[best]) deadline[best] = clock_ms + {16'd0, period[best]};
               else is_armed[best] = 0;
               batch.push_back(status(1, best));
               count++;
            end
         end else if (op == OP_START) begin
            is_armed[slot] = 1;
            is_repeat[slot] = rep;
            period[slot] = delay;
            deadline[slot] = clock_ms + {16'd0, delay};
         end else if (op == OP_CANCEL) begin
            is_armed[slot] = 0;
         end
         if (batch.size() == 0) batch.push_back(status(0, 0));
         batch[batch.size() - 1].last = 1;
         foreach (batch[i]) expected_q.push_back(batch[i]);
      endfunction

      task check_result(timer_result_type got);
         timer_result_type exp;
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing expected", '0, '0);
            return;
         end
         exp = expected_q.pop_front();
         if (got.fired !== exp.fired)
            report_mismatch("fired", 64'(got.fired), 64'(exp.fired));
         if (got.fired_slot !== exp.fired_slot)
            report_mismatch("fired_slot", 64'(got.fired_slot), 64'(exp.fired_slot));
         if (got.queue_empty !== exp.queue_empty)
            report_mismatch("queue_empty", 64'(got.queue_empty), 64'(exp.queue_empty));
         if (got.next_wait_ms !== exp.next_wait_ms)
            report_mismatch("next_wait_ms", 64'(got.next_wait_ms), 64'(exp.next_wait_ms));
         if (got.last !== exp.last)
            report_mismatch("last", 64'(got.last), 64'(exp.last));
      endtask

      task report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
         errors++;
         if (errors <= 50) $display("mismatch %s: got %0h expected %0h", what, got, exp);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;

   timer_scoreboard timers = new();
   int  idle_pct = 35;
   bit  hold_off = 0;
   int  quiet_cycles = 0;

   deadline_timer_queue_core #(.NUM_SLOTS(NSLOT)) u_top (.*);

   always #6 clock = ~clock;

   // Valid stays high after an accepted transaction; the next call drops it when idling.
   task automatic send_request(op_type op, logic [3:0] slot, logic [31:0] delay, bit rep);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, rep, delay, slot, op};
      do @(posedge clock); while (!req_tready);
      timers.note_request(op, slot, delay, rep);
   endtask

   task automatic random_request();
      int pick;
      logic [31:0] delay;
      pick = $urandom_range(99);
      case ($urandom_range(9))
         0: delay = $urandom();
         1: delay = 32'hFFFF_FFFF - $urandom_range(3);
         default: delay = $urandom_range(6);
      endcase
      if (pick < 50) send_request(OP_TICK, 4'($urandom()), $urandom(), 1'($urandom()));
      else if (pick < 80) send_request(OP_START, 4'($urandom()), delay, 1'($urandom()));
      else if (pick < 96)
         send_request(OP_CANCEL, 4'($urandom()), $urandom(), 1'($urandom()));
      else send_request(OP_NOP, 4'($urandom()), $urandom(), 1'($urandom()));
   endtask

   // Receiver side with random back-pressure and an optional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            timers.check_result({rsp_tuser[0], rsp_tdata[3:0], rsp_tdata[4],
                                 rsp_tdata[36:5], rsp_tlast});
         rsp_tready <= !hold_off && ($urandom_range(99) >= idle_pct);
      end
   end

   // No transaction for too long means the block has hung.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_MAX) begin
         $display("deadline_timer_queue_core regression: fail");
         $finish;
      end
   end

   initial begin
      timers.clear();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: every operation, extreme fields, zero delay, the largest wait.
      send_request(OP_TICK, 0, 0, 0);
      send_request(OP_START, 0, 0, 1);
      send_request(OP_START, 15, 32'hFFFF_FFFF, 1);
      send_request(OP_START, 7, 32'hFFFF_FFFF, 0);
      send_request(OP_TICK, 0, 0, 0);
      send_request(OP_TICK, 0, 0, 0);
      send_request(OP_CANCEL, 0, 0, 0);
      send_request(OP_CANCEL, 0, 32'hFFFF_FFFF, 1);
      send_request(OP_NOP, 15, 32'hFFFF_FFFF, 1);
      for (int s = 0; s < NSLOT; s++)
         send_request(OP_START, 4'(s), 32'(s % 2), s % 3 == 0);
      send_request(OP_TICK, 0, 0, 0);
      send_request(OP_TICK, 0, 0, 0);

      // Long hold-off on the receiver while transactions keep coming.
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         repeat (10) random_request();
      join

      // Random part, the middle third without idling.
      for (int i = 0; i < 200; i++) begin
         idle_pct = (i >= 67 && i < 134) ? 0 : 35;
         random_request();
      end
      for (int s = 0; s < NSLOT; s++) send_request(OP_CANCEL, 4'(s), 0, 0);
      req_tvalid <= 0;

      while (timers.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (timers.errors == 0 && timers.expected_q.size() == 0)
         $display("deadline_timer_queue_core regression: pass");
      else
         $display("deadline_timer_queue_core regression: fail");
      $finish;
   end
endmodule

FILE: filelist.f
hdl/dtq_pkg.sv
hdl/dtq_ram.sv
hdl/deadline_timer_queue_core.sv
verif/deadline_timer_queue_core_tb.sv
